FILE: rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII converter
// Request and result structs, cell link types, state codes and the digit map.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_CELLS   = VALUE_WIDTH;   // base 2 needs one digit per bit
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;

    typedef struct packed {
        logic [31:0]        value;
        logic [RADIX_W-1:0] base;
        logic               is_signed;
    } t_itoa_req;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              base_error;
    } t_itoa_res;

    // Carry token handed from one cell to the next
    typedef struct packed {
        logic carry;
        logic valid;
    } t_itoa_link;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_itoa_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_SIGN,
        ST_CONV,
        ST_EMIT,
        ST_TERM
    } t_itoa_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_LOW_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return c;
    endfunction

endpackage

FILE: rtl/itoa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_cell: one digit of the radix conversion chain
// Holds one digit; doubles it and adds the incoming carry, reduces by the
// radix and passes the carry on. Clear zeroes it; in shift mode it takes the digit from below.
// ----------------------------------------------------------------------------
module itoa_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  itoa_pkg::t_itoa_cell_ctrl       i_ctrl,
    input  logic [itoa_pkg::RADIX_W-1:0]    i_radix,
    input  itoa_pkg::t_itoa_link            i_link,
    input  logic [itoa_pkg::DIGIT_W-1:0]    i_digit,
    output itoa_pkg::t_itoa_link            o_link,
    output logic [itoa_pkg::DIGIT_W-1:0]    o_digit
);
    import itoa_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    t_itoa_link         r_link;
    t_itoa_link         n_link;
    logic [RADIX_W-1:0] w_dbl;
    logic [RADIX_W-1:0] w_red;
    logic               w_ge;

    assign w_dbl = {r_digit, i_link.carry};
    assign w_ge  = (w_dbl >= i_radix);
    assign w_red = w_dbl - i_radix;

    always_comb begin
        n_digit = r_digit;
        n_link  = '0;
        priority if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end else if (i_link.valid) begin
            n_digit      = w_ge ? w_red[DIGIT_W-1:0] : w_dbl[DIGIT_W-1:0];
            n_link.carry = w_ge;
            n_link.valid = 1'b1;
        end else begin
            // Hold the digit while no carry token passes
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_link  = r_link;
    assign o_digit = r_digit;

endmodule

FILE: rtl/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: integer to ASCII string, bases 2 to 16
// Converts a 32-bit value into lowercase ASCII digits followed by a NUL.
// ----------------------------------------------------------------------------
// Raise start with a request on i_req while busy is low; the request is taken
// at that edge and busy stays high until the cycle that carries the
// terminating NUL; a new request may be taken at the edge that takes the NUL.
// Characters leave most significant first, one per o_strobe pulse, and the
// receiver cannot stall them: sample o_res on every cycle o_strobe is high.
// The NUL carries last, and base_error when the base was outside 2..16 (then
// the NUL is the only character). A request with a valid base runs the
// conversion wave through the row of 32 digit cells, shifts the row out
// past leading zeros and then sends the NUL; a negative decimal value sends
// its '-' sign before the conversion. An invalid base goes straight to the NUL.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  itoa_pkg::t_itoa_req   i_req,
    output logic                  busy,
    output logic                  o_strobe,
    output itoa_pkg::t_itoa_res   o_res
);
    import itoa_pkg::*;

    localparam int CONV_CYCLES = VALUE_WIDTH + NUM_CELLS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES + 1);
    localparam int REM_W       = $clog2(NUM_CELLS + 1);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_CYCLES - 1);
    localparam logic [CNT_W-1:0] FEED_END  = CNT_W'(VALUE_WIDTH);

    t_itoa_state              r_state;
    t_itoa_state              n_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         n_rem;
    logic                     r_seen;
    logic                     n_seen;
    logic [VALUE_WIDTH-1:0]   r_mag;
    logic [VALUE_WIDTH-1:0]   n_mag;
    logic [RADIX_W-1:0]       r_radix;
    logic [RADIX_W-1:0]       n_radix;
    logic                     r_strobe;
    logic                     n_strobe;
    t_itoa_res                r_res;
    t_itoa_res                n_res;

    logic                     w_accept;
    logic                     w_bad_base;
    logic                     w_neg;
    logic [VALUE_WIDTH-1:0]   w_val;
    logic [DIGIT_W-1:0]       w_top;
    logic                     w_skip;
    t_itoa_cell_ctrl          w_ctrl;

    t_itoa_link               w_link  [NUM_CELLS+1];
    logic [DIGIT_W-1:0]       w_digit [NUM_CELLS+1];

    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_val      = i_req.value[VALUE_WIDTH-1:0];
    assign w_bad_base = (i_req.base < RADIX_MIN) || (i_req.base > RADIX_MAX);
    // Sign shows only in base 10
    assign w_neg      = i_req.is_signed && (i_req.base == RADIX_DEC) &&
                        w_val[VALUE_WIDTH-1];

    // Most significant digit sits in the top cell
    assign w_top  = w_digit[NUM_CELLS];
    // Drop a leading zero unless it is the last digit left
    assign w_skip = (w_top == '0) && !r_seen && (r_rem != REM_W'(1));

    // ------------------------------------------------------------------
    // Cell row: bottom cell gets one value bit per cycle, MSB first
    // ------------------------------------------------------------------
    assign w_ctrl.clear = w_accept;
    assign w_ctrl.shift = (r_state == ST_EMIT);

    assign w_link[0].carry = r_mag[VALUE_WIDTH-1];
    assign w_link[0].valid = (r_state == ST_CONV) && (r_cnt < FEED_END);
    assign w_digit[0]      = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        itoa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_radix (r_radix),
            .i_link  (w_link[g]),
            .i_digit (w_digit[g]),
            .o_link  (w_link[g+1]),
            .o_digit (w_digit[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    priority if (w_bad_base) begin
                        n_state = ST_ERR;
                    end else if (w_neg) begin
                        n_state = ST_SIGN;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_ERR:  n_state = ST_IDLE;
            ST_SIGN: n_state = ST_CONV;
            ST_CONV: begin
                if (r_cnt == CONV_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_rem == REM_W'(1)) begin
                    n_state = ST_TERM;
                end
            end
            ST_TERM: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and result outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_seen   = r_seen;
        n_mag    = r_mag;
        n_radix  = r_radix;
        n_strobe = 1'b0;
        n_res    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // Latch the magnitude; two's complement negate covers the
                    // most negative value too
                    n_mag   = w_neg ? (~w_val + VALUE_WIDTH'(1)) : w_val;
                    n_radix = i_req.base;
                    n_cnt   = '0;
                    n_seen  = 1'b0;
                end
            end
            ST_ERR: begin
                n_strobe         = 1'b1;
                n_res.char_code  = CHAR_NUL;
                n_res.last       = 1'b1;
                n_res.base_error = 1'b1;
            end
            ST_SIGN: begin
                n_strobe        = 1'b1;
                n_res.char_code = CHAR_MINUS;
            end
            ST_CONV: begin
                n_cnt = r_cnt + CNT_W'(1);
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_rem = REM_W'(NUM_CELLS);
            end
            ST_EMIT: begin
                n_rem = r_rem - REM_W'(1);
                if (!w_skip) begin
                    n_seen          = 1'b1;
                    n_strobe        = 1'b1;
                    n_res.char_code = digit_char(w_top);
                end
            end
            ST_TERM: begin
                n_strobe        = 1'b1;
                n_res.char_code = CHAR_NUL;
                n_res.last      = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_seen   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
            r_rem    <= n_rem;
            r_seen   <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_radix <= n_radix;
        r_res   <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_to_ascii_radix
// Sends value/base/sign requests through the start/busy handshake and
// predicts the ASCII character stream each one produces. Every strobed
// character is compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
    import itoa_pkg::*;

    // Expected character stream, built from each accepted request
    class char_stream_board;
        t_itoa_res pending_chars[$];
        int        mismatches = 0;
        string     digit_set = "0123456789abcdef";

        // Spell the request into the characters the block must send
        function void note_request(t_itoa_req req);
            logic [VALUE_WIDTH-1:0] mag;
            logic [VALUE_WIDTH-1:0] radix;
            byte                    digits[$];
            int                     d;
            if (req.base < RADIX_MIN || req.base > RADIX_MAX) begin
                pending_chars.push_back('{char_code: CHAR_NUL, last: 1'b1, base_error: 1'b1});
                return;
            end
            mag   = req.value[VALUE_WIDTH-1:0];
            radix = VALUE_WIDTH'(req.base);
            // Sign shows only in decimal; other bases print the raw pattern
            if (req.is_signed && req.base == RADIX_DEC && mag[VALUE_WIDTH-1]) begin
                pending_chars.push_back('{char_code: CHAR_MINUS, last: 1'b0,
                                          base_error: 1'b0});
                mag = -mag;
            end
            // Zero still yields one '0' because the loop body runs once
            do begin
                d = int'(mag % radix);
                digits.push_front(digit_set[d]);
                mag = mag / radix;
            end while (mag != '0);
            foreach (digits[i]) begin
                pending_chars.push_back('{char_code: digits[i], last: 1'b0, base_error: 1'b0});
            end
            pending_chars.push_back('{char_code: CHAR_NUL, last: 1'b1, base_error: 1'b0});
        endfunction

        function void check_char(t_itoa_res got);
            t_itoa_res want;
            if (pending_chars.size() == 0) begin
                $error("unexpected character %h (last %b, base_error %b)",
                       got.char_code, got.last, got.base_error);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (got.char_code !== want.char_code) begin
                $error("char_code expected %h actual %h", want.char_code, got.char_code);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last expected %b actual %b", want.last, got.last);
                mismatches++;
            end
            if (got.base_error !== want.base_error) begin
                $error("base_error expected %b actual %b", want.base_error, got.base_error);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    // Hang guard sized for 121 requests of the longest kind plus their gaps
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_REQS  = 100;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_itoa_req i_req   = '0;
    logic      busy;
    logic      o_strobe;
    t_itoa_res o_res;

    int unsigned      cycle_count = 0;
    char_stream_board board = new();

    integer_to_ascii_radix i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver cannot stall: take every strobed character at its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_char(o_res);
        end
    end

    // Hold start low for the gap, then present the request and hold it until
    // an edge sees busy low. Start is left high on return; the next call or the caller lowers it.
    task automatic send_request(input t_itoa_req req, input int gap);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note_request(req);
    endtask

    task automatic send_fields(input logic [31:0] value, input logic [RADIX_W-1:0] base,
                               input logic is_signed);
        t_itoa_req req;
        req.value     = value;
        req.base      = base;
        req.is_signed = is_signed;
        send_request(req, ($urandom_range(99) < 35) ? $urandom_range(1, 5) : 0);
    endtask

    // Mix of full-range, small, near-negative and near-limit values so that
    // short and long digit strings both show up
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom();
            1: v = $urandom_range(0, 300);
            2: v = -$urandom_range(1, 1000);
            3: v = 32'h8000_0000 | $urandom_range(0, 15);
            default: v = 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
        return v;
    endfunction

    initial begin
        t_itoa_req req;
        int        gap;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, all ones in the widest and narrowest bases, the
        // decimal sign cases including the most negative value, signed in a
        // non-decimal base, and bases just outside the valid range
        send_fields(32'h0000_0000, 5'd10, 1'b0);
        send_fields(32'h0000_0000, 5'd2,  1'b1);
        send_fields(32'h0000_0000, 5'd16, 1'b0);
        send_fields(32'hFFFF_FFFF, 5'd2,  1'b0);
        send_fields(32'hFFFF_FFFF, 5'd16, 1'b1);
        send_fields(32'hFFFF_FFFF, 5'd10, 1'b0);
        send_fields(32'hFFFF_FFFF, 5'd10, 1'b1);
        send_fields(32'h8000_0000, 5'd10, 1'b1);
        send_fields(32'h8000_0000, 5'd10, 1'b0);
        send_fields(32'h8000_0000, 5'd16, 1'b1);
        send_fields(32'h7FFF_FFFF, 5'd10, 1'b1);
        send_fields(32'hFFFF_CFC7, 5'd8,  1'b1);
        send_fields(32'h0000_3039, 5'd10, 1'b1);
        send_fields(32'hDEAD_BEEF, 5'd3,  1'b0);
        send_fields(32'h1234_5678, 5'd7,  1'b1);
        send_fields(32'hCAFE_F00D, 5'd13, 1'b0);
        send_fields(32'h0000_00FF, 5'd15, 1'b0);
        send_fields(32'h1234_5678, 5'd0,  1'b0);
        send_fields(32'h1234_5678, 5'd1,  1'b1);
        send_fields(32'hFFFF_FFFF, 5'd17, 1'b1);
        send_fields(32'h0000_0000, 5'd31, 1'b0);

        // Random requests; mostly valid bases, a steady share of invalid
        // ones, and one long stretch sent back to back
        for (int n = 0; n < RANDOM_REQS; n++) begin
            req.value     = pick_value();
            req.base      = RADIX_W'(($urandom_range(99) < 85) ? $urandom_range(2, 16)
                          : (($urandom_range(1) == 0) ? $urandom_range(0, 1)
                                                      : $urandom_range(17, 31)));
            req.is_signed = 1'($urandom_range(1));
            if (n >= 40 && n < 80) begin
                gap = 0;
            end else begin
                gap = ($urandom_range(99) < 35) ? $urandom_range(1, 5) : 0;
            end
            send_request(req, gap);
        end
        start <= 1'b0;

        // Drain, then allow one full request's latency for stray characters
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
